FILE: design/multi_channel_periodic_timer_assert.svh
// Assertion macros shared by the timer RTL.
// Used by multi_channel_periodic_timer.sv; expects aclk and aresetn in scope.
`ifndef MULTI_CHANNEL_PERIODIC_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_PERIODIC_TIMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MCPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mcpt_pkg.sv
// Package for the multi-channel periodic timer: field widths, codes, FSM states.
// No dependencies; imported by every module of the block except mcpt_ram.
package mcpt_pkg;

    localparam int TICK_W          = 32;
    localparam int CHAN_FIELD_W    = 4;
    localparam int OP_W            = 3;
    localparam int KIND_W          = 2;
    localparam int DEF_CHANNELS    = 16;
    localparam int DEF_MAX_FIRES   = 32;
    localparam int DEF_COUNT_WIDTH = 8;

    localparam logic [TICK_W-1:0] NONE_TICK = 32'hFFFF_FFFF;
    localparam logic [TICK_W-1:0] SAT_TICK  = 32'hFFFF_FFFE;

    typedef enum logic [OP_W-1:0] {
        OP_TIME     = 3'd0,
        OP_ENABLE   = 3'd1,
        OP_INTERVAL = 3'd2,
        OP_CAPACITY = 3'd3,
        OP_CONSUME  = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        K_POSTED    = 2'd0,
        K_DROPPED   = 2'd1,
        K_DELIVERED = 2'd2,
        K_DONE      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        UM_SCAN,
        UM_DECIDE,
        UM_FIRE,
        UM_CMD
    } unit_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FIRE,
        ST_CMD,
        ST_OUT
    } state_t;

    // Status returned by the shared arithmetic unit.
    typedef struct packed {
        logic  lt;
        logic  cand;
        kind_t kind;
    } unit_stat_t;

    // An interval of zero or all ones means the channel has no period.
    function automatic logic has_interval(input logic [TICK_W-1:0] iv);
        has_interval = (iv != '0) && (iv != NONE_TICK);
    endfunction

endpackage

FILE: design/multi_channel_periodic_timer.sv
// A time update scans every channel once per fire, one channel per cycle through
// the single read port of the channel state RAM; each fire then waits for its word
// to be taken, and the final done word follows one more scan. A channel command
// (enable, interval, capacity, consume, clear) passes through the shared unit and
// presents its single result word at the following edge; an unused opcode or an
// out-of-range channel skips the unit. The block takes no new input word until the
// last result word of the current one has been accepted. The channel RAM needs no
// clearing pass: per-channel valid bits make unwritten channels read as disabled
// with no interval and no due time.
// Top level of the timer; depends on mcpt_pkg, mcpt_ram, mcpt_ctrl and the macro header.
module multi_channel_periodic_timer import mcpt_pkg::*; #(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int MAX_FIRES   = DEF_MAX_FIRES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] chan, [35:4] operand_value, [39:36] zero
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] out_chan, [35:4] due_tick, [39:36] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last word caused by the input word
);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int REC_W = 1 + 2 * TICK_W + 2 * COUNT_WIDTH;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [REC_W-1:0]        ram_q;
    logic [REC_W-1:0]        wr_rec;
    logic [REC_W-1:0]        rd_rec;
    logic [CHANNELS-1:0]     written_reg;
    logic                    rd_written_reg;
    logic                    rec_en, new_en;
    logic [TICK_W-1:0]       rec_iv, rec_due, new_iv, new_due;
    logic [COUNT_WIDTH-1:0]  rec_cap, rec_pend, new_cap, new_pend;
    logic [CHAN_FIELD_W-1:0] out_chan;
    logic [TICK_W-1:0]       due_tick;

    mcpt_ram #(
        .WIDTH (REC_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_rec),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Written flags: a channel never written reads as its reset record.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_rec = rd_written_reg ? ram_q
                  : {1'b0, {TICK_W{1'b0}}, NONE_TICK, {COUNT_WIDTH{1'b0}}, {COUNT_WIDTH{1'b0}}};
    assign {rec_en, rec_iv, rec_due, rec_cap, rec_pend} = rd_rec;
    assign wr_rec = {new_en, new_iv, new_due, new_cap, new_pend};

    mcpt_ctrl #(
        .CHANNELS    (CHANNELS),
        .MAX_FIRES   (MAX_FIRES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_op     (s_tuser),
        .s_chan   (s_tdata[3:0]),
        .s_val    (s_tdata[35:4]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_kind   (m_tuser),
        .m_chan   (out_chan),
        .m_tick   (due_tick),
        .m_last   (m_tlast),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rec_en   (rec_en),
        .rec_iv   (rec_iv),
        .rec_due  (rec_due),
        .rec_cap  (rec_cap),
        .rec_pend (rec_pend),
        .new_en   (new_en),
        .new_iv   (new_iv),
        .new_due  (new_due),
        .new_cap  (new_cap),
        .new_pend (new_pend)
    );

    assign m_tdata = {4'b0000, due_tick, out_chan};

    // Checks on the sequencing of input and result words.
`include "multi_channel_periodic_timer_assert.svh"

    `MCPT_ASSERT_NOW(a_busy_excl, s_tready, !m_tvalid, "input ready while a result word is held")
    `MCPT_ASSERT_NOW(a_fire_not_last, m_tvalid && (m_tuser == K_POSTED || m_tuser == K_DROPPED), !m_tlast, "fire word marked last")
    `MCPT_ASSERT_NEXT(a_last_frees, m_tvalid && m_tready && m_tlast, s_tready, "not ready after last word")
    `MCPT_ASSERT_NEXT(a_more_busy, m_tvalid && m_tready && !m_tlast, !s_tready, "ready before last word")

endmodule

FILE: design/mcpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mcpt_unit.sv
// Shared arithmetic unit: one saturating adder and one 32-bit comparator,
// plus the per-channel record update. Depends on mcpt_pkg.
module mcpt_unit import mcpt_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  unit_mode_t              mode,
    input  op_t                     op,
    input  logic [TICK_W-1:0]       operand,
    input  logic [TICK_W-1:0]       cur_time,
    input  logic [TICK_W-1:0]       best_due,
    input  logic                    found,
    input  logic                    rec_en,
    input  logic [TICK_W-1:0]       rec_iv,
    input  logic [TICK_W-1:0]       rec_due,
    input  logic [COUNT_WIDTH-1:0]  rec_cap,
    input  logic [COUNT_WIDTH-1:0]  rec_pend,
    output logic                    new_en,
    output logic [TICK_W-1:0]       new_iv,
    output logic [TICK_W-1:0]       new_due,
    output logic [COUNT_WIDTH-1:0]  new_cap,
    output logic [COUNT_WIDTH-1:0]  new_pend,
    output unit_stat_t              stat
);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [TICK_W-1:0] add_a;
    logic [TICK_W-1:0] add_b;
    logic [TICK_W:0]   sum;
    logic [TICK_W-1:0] sat_sum;
    logic [TICK_W-1:0] cmp_a;
    logic              lt;
    logic              cand;
    kind_t             kind_val;
    logic              en_val;

    // Adder operands: a fire advances from its due time, a re-arm from now.
    always_comb begin
        add_a   = (mode == UM_FIRE) ? rec_due : cur_time;
        add_b   = ((mode == UM_CMD) && (op == OP_INTERVAL)) ? operand : rec_iv;
        sum     = {1'b0, add_a} + {1'b0, add_b};
        sat_sum = (sum > {1'b0, SAT_TICK}) ? SAT_TICK : sum[TICK_W-1:0];
    end

    // Comparator: scan compares a due time, decide compares the current time.
    always_comb begin
        cmp_a = (mode == UM_DECIDE) ? cur_time : rec_due;
        lt    = cmp_a < best_due;
        cand  = rec_en && (rec_due != NONE_TICK) && (!found || lt);
    end

    assign en_val = |operand;
    assign stat   = {lt, cand, kind_val};

    // Record update for a fire or a channel command.
    always_comb begin
        new_en   = rec_en;
        new_iv   = rec_iv;
        new_due  = rec_due;
        new_cap  = rec_cap;
        new_pend = rec_pend;
        kind_val = K_DONE;
        case (mode)
            UM_FIRE: begin
                if (has_interval(rec_iv)) begin
                    if ((rec_cap == '0) || (rec_pend < rec_cap)) begin
                        kind_val = K_POSTED;
                        if (rec_pend < CNT_MAX) begin
                            new_pend = rec_pend + COUNT_WIDTH'(1);
                        end
                    end else begin
                        kind_val = K_DROPPED;
                    end
                    new_due = sat_sum;
                end else begin
                    new_due = NONE_TICK;
                end
            end
            UM_CMD: begin
                case (op)
                    OP_ENABLE: begin
                        new_pend = '0;
                        new_en   = en_val;
                        new_due  = (en_val && has_interval(rec_iv)) ? sat_sum : NONE_TICK;
                    end
                    OP_INTERVAL: begin
                        if (rec_iv != operand) begin
                            new_pend = '0;
                            new_iv   = operand;
                            new_due  = (rec_en && has_interval(operand)) ? sat_sum : NONE_TICK;
                        end
                    end
                    OP_CAPACITY: begin
                        new_cap = (operand > TICK_W'(CNT_MAX)) ? CNT_MAX
                                                               : operand[COUNT_WIDTH-1:0];
                    end
                    OP_CONSUME: begin
                        if (rec_pend != '0) begin
                            new_pend = rec_pend - COUNT_WIDTH'(1);
                        end
                        if (rec_en && has_interval(rec_iv)) begin
                            kind_val = K_DELIVERED;
                        end
                    end
                    OP_CLEAR: begin
                        new_pend = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: design/mcpt_ctrl.sv
// Sequencer of the timer: command dispatch, channel scan, fire loop and the
// output register. Depends on mcpt_pkg and mcpt_unit.
module mcpt_ctrl import mcpt_pkg::*; #(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int MAX_FIRES   = DEF_MAX_FIRES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_op,
    input  logic [CHAN_FIELD_W-1:0] s_chan,
    input  logic [TICK_W-1:0]       s_val,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [KIND_W-1:0]       m_kind,
    output logic [CHAN_FIELD_W-1:0] m_chan,
    output logic [TICK_W-1:0]       m_tick,
    output logic                    m_last,
    output logic                    rd_en,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
    output logic                    wr_en,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
    input  logic                    rec_en,
    input  logic [TICK_W-1:0]       rec_iv,
    input  logic [TICK_W-1:0]       rec_due,
    input  logic [COUNT_WIDTH-1:0]  rec_cap,
    input  logic [COUNT_WIDTH-1:0]  rec_pend,
    output logic                    new_en,
    output logic [TICK_W-1:0]       new_iv,
    output logic [TICK_W-1:0]       new_due,
    output logic [COUNT_WIDTH-1:0]  new_cap,
    output logic [COUNT_WIDTH-1:0]  new_pend
);
    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(CHANNELS + 1);
    localparam int FIRE_W = $clog2(MAX_FIRES + 1);

    state_t                  state_reg, state_next;
    state_t                  post_reg, post_next;
    op_t                     op_reg, op_next;
    logic [CHAN_FIELD_W-1:0] chan_reg, chan_next;
    logic [TICK_W-1:0]       val_reg, val_next;
    logic [TICK_W-1:0]       ct_reg, ct_next;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [TICK_W-1:0]       best_due_reg, best_due_next;
    logic [FIRE_W-1:0]       fires_reg, fires_next;
    logic                    m_valid_reg, m_valid_next;
    kind_t                   kind_reg, kind_next;
    logic [CHAN_FIELD_W-1:0] ochan_reg, ochan_next;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic                    last_reg, last_next;

    op_t        in_op;
    logic       cmd_ok;
    logic       scan_more;
    logic       stop_fire;
    unit_mode_t mode;
    unit_stat_t stat;

    assign in_op     = op_t'(s_op);
    assign cmd_ok    = (in_op != OP_TIME) && (in_op <= OP_CLEAR) && (32'(s_chan) < CHANNELS);
    assign scan_more = 32'(scan_reg) < CHANNELS;
    assign stop_fire = (fires_reg == FIRE_W'(MAX_FIRES)) || !found_reg || stat.lt;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_kind  = kind_reg;
    assign m_chan  = ochan_reg;
    assign m_tick  = tick_reg;
    assign m_last  = last_reg;

    // Unit mode follows the sequencer state.
    always_comb begin
        case (state_reg)
            ST_DECIDE: mode = UM_DECIDE;
            ST_FIRE:   mode = UM_FIRE;
            ST_CMD:    mode = UM_CMD;
            default:   mode = UM_SCAN;
        endcase
    end

    mcpt_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_unit (
        .mode     (mode),
        .op       (op_reg),
        .operand  (val_reg),
        .cur_time (ct_reg),
        .best_due (best_due_reg),
        .found    (found_reg),
        .rec_en   (rec_en),
        .rec_iv   (rec_iv),
        .rec_due  (rec_due),
        .rec_cap  (rec_cap),
        .rec_pend (rec_pend),
        .new_en   (new_en),
        .new_iv   (new_iv),
        .new_due  (new_due),
        .new_cap  (new_cap),
        .new_pend (new_pend),
        .stat     (stat)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (in_op == OP_TIME) begin
                        state_next = ST_SCAN;
                    end else if (cmd_ok) begin
                        state_next = ST_CMD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                if (!scan_more) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = stop_fire ? ST_OUT : ST_FIRE;
            ST_FIRE:   state_next = ST_OUT;
            ST_CMD:    state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = post_reg;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory strobes and output word.
    always_comb begin
        post_next     = post_reg;
        op_next       = op_reg;
        chan_next     = chan_reg;
        val_next      = val_reg;
        ct_next       = ct_reg;
        scan_next     = scan_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_due_next = best_due_reg;
        fires_next    = fires_reg;
        m_valid_next  = m_valid_reg;
        kind_next     = kind_reg;
        ochan_next    = ochan_reg;
        tick_next     = tick_reg;
        last_next     = last_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next   = in_op;
                    chan_next = s_chan;
                    val_next  = s_val;
                    if (in_op == OP_TIME) begin
                        ct_next    = s_val;
                        fires_next = '0;
                        scan_next  = '0;
                        found_next = 1'b0;
                    end else if (cmd_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = IDX_W'(s_chan);
                    end else begin
                        m_valid_next = 1'b1;
                        kind_next    = K_DONE;
                        ochan_next   = s_chan;
                        tick_next    = ct_reg;
                        last_next    = 1'b1;
                        post_next    = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                // Read one channel a cycle; the record read last cycle is compared now.
                if (scan_more) begin
                    rd_en     = 1'b1;
                    rd_addr   = IDX_W'(scan_reg);
                    scan_next = scan_reg + CNT_W'(1);
                end
                if ((scan_reg != '0) && stat.cand) begin
                    found_next    = 1'b1;
                    best_idx_next = IDX_W'(scan_reg - CNT_W'(1));
                    best_due_next = rec_due;
                end
            end
            ST_DECIDE: begin
                if (stop_fire) begin
                    m_valid_next = 1'b1;
                    kind_next    = K_DONE;
                    ochan_next   = '0;
                    tick_next    = ct_reg;
                    last_next    = 1'b1;
                    post_next    = ST_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = best_idx_reg;
                end
            end
            ST_FIRE: begin
                wr_en        = 1'b1;
                wr_addr      = best_idx_reg;
                m_valid_next = 1'b1;
                kind_next    = stat.kind;
                ochan_next   = CHAN_FIELD_W'(best_idx_reg);
                tick_next    = rec_due;
                last_next    = 1'b0;
                fires_next   = fires_reg + FIRE_W'(1);
                scan_next    = '0;
                found_next   = 1'b0;
                post_next    = ST_SCAN;
            end
            ST_CMD: begin
                wr_en        = 1'b1;
                wr_addr      = IDX_W'(chan_reg);
                m_valid_next = 1'b1;
                kind_next    = stat.kind;
                ochan_next   = chan_reg;
                tick_next    = ct_reg;
                last_next    = 1'b1;
                post_next    = ST_IDLE;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            post_reg    <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ct_reg      <= '0;
            fires_reg   <= '0;
            scan_reg    <= '0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            post_reg    <= post_next;
            m_valid_reg <= m_valid_next;
            ct_reg      <= ct_next;
            fires_reg   <= fires_next;
            scan_reg    <= scan_next;
            found_reg   <= found_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        chan_reg     <= chan_next;
        val_reg      <= val_next;
        best_idx_reg <= best_idx_next;
        best_due_reg <= best_due_next;
        kind_reg     <= kind_next;
        ochan_reg    <= ochan_next;
        tick_reg     <= tick_next;
        last_reg     <= last_next;
    end

endmodule
